FILE: hdl/mwps_pkg.sv
// shared types and constants of the masked word pattern search
package mwps_pkg;

  localparam int unsigned MAX_PATTERN_WORDS = 8;
  localparam int unsigned MAX_BUFFER_WORDS  = 16777216;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned IDX_W  = 24;
  localparam int unsigned SLOT_W = 3;
  localparam int unsigned CFG_W  = 4;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  // item function codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_DATA = 1'b1;

  // register addresses
  localparam logic [APB_ADDR_W-1:0] ADDR_PATTERN_WORDS = 3'd0;

  localparam logic [CFG_W-1:0] PATTERN_WORDS_RST = 4'd1;

  typedef struct packed {
    logic              shift;
    logic              load;
    logic [SLOT_W-1:0] slot;
  } cell_ctrl_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] match_index;
    logic             overflow;
  } res_t;

endpackage

FILE: hdl/mwps_cell.sv
// one window cell: a history word, one pattern slot and its masked compare
module mwps_cell #(
  parameter int unsigned MAX_PATTERN_WORDS = mwps_pkg::MAX_PATTERN_WORDS,
  parameter int unsigned CELL_IDX          = 0,
  localparam int unsigned LEN_W = $clog2(MAX_PATTERN_WORDS + 1),
  localparam int unsigned SEL_W = (MAX_PATTERN_WORDS > 1) ? $clog2(MAX_PATTERN_WORDS) : 1
) (
  input  logic                                              clk_i,
  input  mwps_pkg::cell_ctrl_t                              ctrl_i,
  input  logic [mwps_pkg::DATA_W-1:0]                       pattern_word_i,
  input  logic [mwps_pkg::DATA_W-1:0]                       mask_word_i,
  input  logic [mwps_pkg::DATA_W-1:0]                       word_i,
  input  logic [MAX_PATTERN_WORDS-1:0][mwps_pkg::DATA_W-1:0] window_i,
  input  logic [LEN_W-1:0]                                  len_i,
  output logic [mwps_pkg::DATA_W-1:0]                       hist_o,
  output logic                                              match_o
);

  logic [mwps_pkg::DATA_W-1:0] hist_q;
  logic [mwps_pkg::DATA_W-1:0] pat_q;
  logic [mwps_pkg::DATA_W-1:0] mask_q;
  logic                        active;
  logic [LEN_W-1:0]            pos;
  logic [SEL_W-1:0]            sel;
  logic [mwps_pkg::DATA_W-1:0] sel_word;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      hist_q <= word_i;
    end
    if (ctrl_i.load && (32'(ctrl_i.slot) == 32'(CELL_IDX))) begin
      pat_q  <= pattern_word_i;
      mask_q <= mask_word_i;
    end
  end

  // slot j checks the window word that is len-1-j words old
  always_comb begin
    active   = LEN_W'(CELL_IDX) < len_i;
    pos      = LEN_W'(len_i - LEN_W'(1) - LEN_W'(CELL_IDX));
    sel      = pos[SEL_W-1:0];
    sel_word = active ? window_i[sel] : '0;
    match_o  = !active || ((sel_word & mask_q) == pat_q);
  end

  assign hist_o = hist_q;

endmodule

FILE: hdl/mwps_outbuf.sv
// two-entry result buffer: output register plus skid register
module mwps_outbuf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  mwps_pkg::res_t      res_i,
  output logic                full_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mwps_pkg::res_t      res_o
);

  logic           out_valid_q, out_valid_d;
  logic           skid_valid_q, skid_valid_d;
  mwps_pkg::res_t out_q, out_d;
  mwps_pkg::res_t skid_q, skid_d;
  logic           out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  // a push only comes while the skid register is empty
  always_comb begin
    out_load     = !out_valid_q || !out_stall_i;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (out_load) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (out_load) begin
        out_d       = res_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res_i;
        skid_valid_d = 1'b1;
      end
    end else if (out_load) begin
      out_valid_d = 1'b0;
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

FILE: hdl/masked_word_pattern_search.sv
// masked word pattern search: one item per clock in, at most one result per buffer out
// The block takes one item every clock cycle when the result side does not stall. Each
// data word enters a row of MAX_PATTERN_WORDS cells; each cell holds one history word and
// one pattern/mask slot, and all active cells compare in the cycle the word is accepted, so
// a found result, or the not-found result on a buffer's last word, enters the output
// register, or the skid register on a stall. Load items write a slot and give no result.
// A two-entry output buffer lets input continue while a result waits; in_stall_o rises
// only when both entries are full. pattern_words lives at address 0 of the APB port.
module masked_word_pattern_search #(
  parameter int unsigned MAX_PATTERN_WORDS = mwps_pkg::MAX_PATTERN_WORDS,
  parameter int unsigned MAX_BUFFER_WORDS  = mwps_pkg::MAX_BUFFER_WORDS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [mwps_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [mwps_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [mwps_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready,
  // input items
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               func_i,
  input  logic [mwps_pkg::SLOT_W-1:0]        slot_i,
  input  logic [mwps_pkg::DATA_W-1:0]        pattern_word_i,
  input  logic [mwps_pkg::DATA_W-1:0]        mask_word_i,
  input  logic [mwps_pkg::DATA_W-1:0]        data_word_i,
  input  logic                               last_word_i,
  // result items
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               found_o,
  output logic [mwps_pkg::IDX_W-1:0]         match_index_o,
  output logic                               overflow_o
);

  localparam int unsigned LEN_W = $clog2(MAX_PATTERN_WORDS + 1);
  localparam int unsigned CNT_W = $clog2(MAX_BUFFER_WORDS + 1);
  localparam int unsigned CMP_W = (CNT_W > mwps_pkg::IDX_W) ? CNT_W : mwps_pkg::IDX_W;

  logic [mwps_pkg::CFG_W-1:0] pattern_words_q;
  logic [CNT_W-1:0]           count_q, count_d;
  logic                       match_latched_q, match_latched_d;
  logic                       overflow_seen_q, overflow_seen_d;

  logic [LEN_W-1:0]           len;
  logic                       cfg_wr;
  logic                       in_acc;
  logic                       data_acc;
  logic                       run;
  logic                       cnt_full;
  logic [CNT_W-1:0]           count_new;
  logic                       enough;
  logic [CMP_W-1:0]           diff;
  logic                       hit;
  logic                       latched_next;
  logic                       ovf_next;
  logic                       res_push;
  logic                       buf_full;
  mwps_pkg::res_t             res;
  mwps_pkg::res_t             res_out;
  mwps_pkg::cell_ctrl_t       cell_ctrl;

  logic [MAX_PATTERN_WORDS-1:0][mwps_pkg::DATA_W-1:0] hist;
  logic [MAX_PATTERN_WORDS-1:0][mwps_pkg::DATA_W-1:0] window;
  logic [MAX_PATTERN_WORDS-1:0]                       cell_match;

  // configuration port
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_words_q <= mwps_pkg::PATTERN_WORDS_RST;
    end else if (cfg_wr && (paddr == mwps_pkg::ADDR_PATTERN_WORDS)) begin
      pattern_words_q <= pwdata[mwps_pkg::CFG_W-1:0];
    end
  end

  always_comb begin
    if (paddr == mwps_pkg::ADDR_PATTERN_WORDS) begin
      prdata = mwps_pkg::APB_DATA_W'(pattern_words_q);
    end else begin
      prdata = '0;
    end
  end

  // window length clamped to 1..MAX_PATTERN_WORDS
  always_comb begin
    if (pattern_words_q == '0) begin
      len = LEN_W'(1);
    end else if (32'(pattern_words_q) > MAX_PATTERN_WORDS) begin
      len = LEN_W'(MAX_PATTERN_WORDS);
    end else begin
      len = LEN_W'(pattern_words_q);
    end
  end

  // cell row
  assign in_acc   = in_valid_i && !in_stall_o;
  assign data_acc = in_acc && (func_i == mwps_pkg::FUNC_DATA);
  assign run      = data_acc && !match_latched_q;
  assign cnt_full = count_q >= CNT_W'(MAX_BUFFER_WORDS);

  assign cell_ctrl.shift = run && !cnt_full;
  assign cell_ctrl.load  = in_acc && (func_i == mwps_pkg::FUNC_LOAD);
  assign cell_ctrl.slot  = slot_i;

  // window as it stands after this word has shifted in
  always_comb begin
    window[0] = data_word_i;
    for (int k = 1; k < MAX_PATTERN_WORDS; k++) begin
      window[k] = hist[k-1];
    end
  end

  for (genvar g = 0; g < MAX_PATTERN_WORDS; g++) begin : g_cell
    mwps_cell #(
      .MAX_PATTERN_WORDS (MAX_PATTERN_WORDS),
      .CELL_IDX          (g)
    ) u_cell (
      .clk_i          (clk_i),
      .ctrl_i         (cell_ctrl),
      .pattern_word_i (pattern_word_i),
      .mask_word_i    (mask_word_i),
      .word_i         (window[g]),
      .window_i       (window),
      .len_i          (len),
      .hist_o         (hist[g]),
      .match_o        (cell_match[g])
    );
  end

  // per-buffer sequencing
  always_comb begin
    count_new    = count_q + CNT_W'(1);
    enough       = CMP_W'(count_new) >= CMP_W'(len);
    diff         = CMP_W'(count_new) - CMP_W'(len);
    hit          = cell_ctrl.shift && enough && (&cell_match);
    latched_next = match_latched_q || hit;
    ovf_next     = overflow_seen_q || (run && cnt_full);

    count_d         = cell_ctrl.shift ? count_new : count_q;
    match_latched_d = latched_next;
    overflow_seen_d = ovf_next;
    if (data_acc && last_word_i) begin
      count_d         = '0;
      match_latched_d = 1'b0;
      overflow_seen_d = 1'b0;
    end

    res_push          = hit || (data_acc && last_word_i && !latched_next);
    res.found         = hit;
    res.match_index   = hit ? diff[mwps_pkg::IDX_W-1:0] : '0;
    res.overflow      = hit ? 1'b0 : ovf_next;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q         <= '0;
      match_latched_q <= 1'b0;
      overflow_seen_q <= 1'b0;
    end else begin
      count_q         <= count_d;
      match_latched_q <= match_latched_d;
      overflow_seen_q <= overflow_seen_d;
    end
  end

  mwps_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_push),
    .res_i       (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_out)
  );

  assign in_stall_o    = buf_full;
  assign found_o       = res_out.found;
  assign match_index_o = res_out.match_index;
  assign overflow_o    = res_out.overflow;

  // checks
  a_stall_needs_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled while output register empty");

  a_found_no_ovf : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && found_o) |-> !overflow_o)
    else $error("found result carries overflow");

  a_count_limit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_BUFFER_WORDS))
    else $error("word count beyond limit");

  a_hit_latches : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hit && !last_word_i) |=> match_latched_q)
    else $error("match not latched after hit");

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench of the masked word pattern search with a predicting scoreboard
module testbench;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned PHASE_ITEMS = 192;
  localparam int unsigned NUM_PHASES  = 10;
  localparam int unsigned DRAIN_WAIT  = 8;

  typedef struct {
    logic                        func;
    logic [mwps_pkg::SLOT_W-1:0] slot;
    logic [mwps_pkg::DATA_W-1:0] pattern;
    logic [mwps_pkg::DATA_W-1:0] mask;
    logic [mwps_pkg::DATA_W-1:0] data;
    logic                        last;
  } search_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                            psel = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite = 1'b0;
  logic [mwps_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [mwps_pkg::APB_DATA_W-1:0] pwdata = '0;
  logic [mwps_pkg::APB_DATA_W-1:0] prdata;
  logic                            pready;

  logic                        in_valid_i = 1'b0;
  logic                        in_stall_o;
  logic                        func_i = 1'b0;
  logic [mwps_pkg::SLOT_W-1:0] slot_i = '0;
  logic [mwps_pkg::DATA_W-1:0] pattern_word_i = '0;
  logic [mwps_pkg::DATA_W-1:0] mask_word_i = '0;
  logic [mwps_pkg::DATA_W-1:0] data_word_i = '0;
  logic                        last_word_i = 1'b0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic                        found_o;
  logic [mwps_pkg::IDX_W-1:0]  match_index_o;
  logic                        overflow_o;

  masked_word_pattern_search u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .slot_i         (slot_i),
    .pattern_word_i (pattern_word_i),
    .mask_word_i    (mask_word_i),
    .data_word_i    (data_word_i),
    .last_word_i    (last_word_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .found_o        (found_o),
    .match_index_o  (match_index_o),
    .overflow_o     (overflow_o)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  search_item_t   search_items_q[$];
  mwps_pkg::res_t predicted_reports_q[$];

  // predictor state
  logic [mwps_pkg::DATA_W-1:0] hist_words [mwps_pkg::MAX_PATTERN_WORDS];
  logic [mwps_pkg::DATA_W-1:0] pat_slots  [mwps_pkg::MAX_PATTERN_WORDS];
  logic [mwps_pkg::DATA_W-1:0] msk_slots  [mwps_pkg::MAX_PATTERN_WORDS];
  longint unsigned             seen_words = 0;
  bit                          hit_latched = 1'b0;
  bit                          ovf_latched = 1'b0;
  logic [mwps_pkg::CFG_W-1:0]  cfg_words = mwps_pkg::PATTERN_WORDS_RST;

  // stimulus-side copy of the slots, as they will be when the queued items are taken
  logic [mwps_pkg::DATA_W-1:0] gen_pat [mwps_pkg::MAX_PATTERN_WORDS];
  logic [mwps_pkg::DATA_W-1:0] gen_msk [mwps_pkg::MAX_PATTERN_WORDS];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_arm = 1'b0;
  int unsigned hold_cnt = 0;
  int unsigned cycle_cnt = 0;

  int unsigned failures = 0;
  int unsigned words_taken = 0;
  int unsigned loads_taken = 0;
  int unsigned found_cnt = 0;
  int unsigned miss_cnt = 0;
  int unsigned phase_items = 0;

  function automatic int unsigned window_len(logic [mwps_pkg::CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > mwps_pkg::MAX_PATTERN_WORDS) return mwps_pkg::MAX_PATTERN_WORDS;
    return 32'(v);
  endfunction

  task automatic predict_search(search_item_t it);
    int unsigned    wl;
    bit             hit;
    mwps_pkg::res_t rep;
    if (it.func == mwps_pkg::FUNC_LOAD) begin
      if (it.slot < mwps_pkg::MAX_PATTERN_WORDS) begin
        pat_slots[it.slot] = it.pattern;
        msk_slots[it.slot] = it.mask;
      end
      return;
    end
    if (!hit_latched) begin
      if (seen_words >= mwps_pkg::MAX_BUFFER_WORDS) begin
        ovf_latched = 1'b1;
      end else begin
        wl = window_len(cfg_words);
        for (int k = mwps_pkg::MAX_PATTERN_WORDS - 1; k > 0; k--)
          hist_words[k] = hist_words[k-1];
        hist_words[0] = it.data;
        seen_words++;
        if (seen_words >= wl) begin
          hit = 1'b1;
          // slot 0 lines up with the oldest word of the window
          for (int j = 0; j < wl; j++) begin
            if ((hist_words[wl-1-j] & msk_slots[j]) != pat_slots[j]) hit = 1'b0;
          end
          if (hit) begin
            hit_latched = 1'b1;
            rep.found = 1'b1;
            rep.match_index = mwps_pkg::IDX_W'(seen_words - wl);
            rep.overflow = 1'b0;
            predicted_reports_q.push_back(rep);
          end
        end
      end
    end
    if (it.last) begin
      if (!hit_latched) begin
        rep.found = 1'b0;
        rep.match_index = '0;
        rep.overflow = ovf_latched;
        predicted_reports_q.push_back(rep);
      end
      for (int k = 0; k < mwps_pkg::MAX_PATTERN_WORDS; k++) hist_words[k] = '0;
      seen_words = 0;
      hit_latched = 1'b0;
      ovf_latched = 1'b0;
    end
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin : drive_items
    search_item_t cur;
    search_item_t nxt;
    bit           taken;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      taken = in_valid_i && !in_stall_o;
      if (taken) begin
        cur.func = func_i;
        cur.slot = slot_i;
        cur.pattern = pattern_word_i;
        cur.mask = mask_word_i;
        cur.data = data_word_i;
        cur.last = last_word_i;
        predict_search(cur);
        if (cur.func == mwps_pkg::FUNC_LOAD) loads_taken++;
        else words_taken++;
      end
      if (!in_valid_i || taken) begin
        if (search_items_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = search_items_q.pop_front();
          func_i <= nxt.func;
          slot_i <= nxt.slot;
          pattern_word_i <= nxt.pattern;
          mask_word_i <= nxt.mask;
          data_word_i <= nxt.data;
          last_word_i <= nxt.last;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_cnt <= 0;
    end else if (hold_arm) begin
      hold_cnt <= HOLD_CYCLES;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin : check_reports
    mwps_pkg::res_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (found_o) found_cnt++;
        else miss_cnt++;
        if (predicted_reports_q.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("unexpected result: found=%0b index=%0d overflow=%0b",
                     found_o, match_index_o, overflow_o);
        end else begin
          want = predicted_reports_q.pop_front();
          if (found_o !== want.found || match_index_o !== want.match_index ||
              overflow_o !== want.overflow) begin
            failures++;
            if (failures <= 10)
              $display("result mismatch: expected %0b/%0d/%0b, got %0b/%0d/%0b",
                       want.found, want.match_index, want.overflow,
                       found_o, match_index_o, overflow_o);
          end
        end
      end
      out_stall_i <= (hold_cnt != 0) || ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic apb_write(logic [mwps_pkg::APB_ADDR_W-1:0] addr,
                           logic [mwps_pkg::APB_DATA_W-1:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == mwps_pkg::ADDR_PATTERN_WORDS) cfg_words = value[mwps_pkg::CFG_W-1:0];
  endtask

  task automatic apb_check(logic [mwps_pkg::APB_ADDR_W-1:0] addr,
                           logic [mwps_pkg::CFG_W-1:0] want);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[mwps_pkg::CFG_W-1:0] !== want) begin
      failures++;
      if (failures <= 10)
        $display("register readback mismatch: expected %0d, got %0d",
                 want, prdata[mwps_pkg::CFG_W-1:0]);
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (in_valid_i || search_items_q.size() != 0 || predicted_reports_q.size() != 0);
    // loads give no result, so the block may still be busy with one
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic queue_load(logic [mwps_pkg::SLOT_W-1:0] slot,
                            logic [mwps_pkg::DATA_W-1:0] pat,
                            logic [mwps_pkg::DATA_W-1:0] msk);
    search_item_t it;
    it.func = mwps_pkg::FUNC_LOAD;
    it.slot = slot;
    it.pattern = pat;
    it.mask = msk;
    it.data = $urandom();
    it.last = 1'($urandom_range(1));
    gen_pat[slot] = pat;
    gen_msk[slot] = msk;
    search_items_q.push_back(it);
    phase_items++;
  endtask

  task automatic queue_word(logic [mwps_pkg::DATA_W-1:0] data, logic last);
    search_item_t it;
    it.func = mwps_pkg::FUNC_DATA;
    it.slot = mwps_pkg::SLOT_W'($urandom_range(7));
    it.pattern = $urandom();
    it.mask = $urandom();
    it.data = data;
    it.last = last;
    search_items_q.push_back(it);
    phase_items++;
  endtask

  task automatic queue_random_load();
    logic [mwps_pkg::DATA_W-1:0] msk;
    logic [mwps_pkg::DATA_W-1:0] pat;
    case ($urandom_range(4))
      0: msk = '0;
      1: msk = '1;
      2: msk = $urandom() & 32'h00ff_00ff;
      default: msk = $urandom();
    endcase
    // a pattern with bits outside its mask can never match
    pat = ($urandom_range(9) == 0) ? $urandom() : ($urandom() & msk);
    queue_load(mwps_pkg::SLOT_W'($urandom_range(7)), pat, msk);
  endtask

  task automatic queue_buffer();
    int unsigned                 wl;
    int unsigned                 blen;
    int unsigned                 start;
    int unsigned                 k;
    logic [mwps_pkg::DATA_W-1:0] words[$];
    wl = window_len(cfg_words);
    blen = ($urandom_range(9) == 0) ? $urandom_range(40, wl + 1) : $urandom_range(wl + 3, 1);
    for (int i = 0; i < blen; i++) words.push_back($urandom());
    if (blen >= wl && $urandom_range(99) < 70) begin
      start = $urandom_range(blen - wl, 0);
      for (int j = 0; j < wl; j++)
        words[start+j] = (gen_pat[j] & gen_msk[j]) | ($urandom() & ~gen_msk[j]);
      // near miss: one flipped bit somewhere in the planted window
      if ($urandom_range(4) == 0) begin
        k = start + $urandom_range(wl - 1, 0);
        words[k] = words[k] ^ (32'h1 << $urandom_range(31));
      end
    end
    for (int i = 0; i < blen; i++) begin
      if ($urandom_range(29) == 0) queue_random_load();
      queue_word(words[i], i == blen - 1);
    end
  endtask

  initial begin : stimulus
    logic [mwps_pkg::CFG_W-1:0] cfg_plan [NUM_PHASES];
    cfg_plan = '{4'd8, 4'd0, 4'd15, 4'd2, 4'd5, 4'd8, 4'd1, 4'd7, 4'd3, 4'd4};
    for (int k = 0; k < mwps_pkg::MAX_PATTERN_WORDS; k++) hist_words[k] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    apb_check(mwps_pkg::ADDR_PATTERN_WORDS, mwps_pkg::PATTERN_WORDS_RST);

    // directed: every slot written before any compare reads it
    queue_load(mwps_pkg::SLOT_W'(0), 32'hffff_ffff, 32'hffff_ffff);
    queue_load(mwps_pkg::SLOT_W'(1), 32'h0000_0000, 32'h0000_0000);
    for (int s = 2; s < 7; s++) queue_load(mwps_pkg::SLOT_W'(s), 32'h0000_0000, 32'hffff_ffff);
    queue_load(mwps_pkg::SLOT_W'(7), 32'h8000_0001, 32'h8000_0001);
    queue_word(32'h0000_0000, 1'b1);
    queue_word(32'hffff_ffff, 1'b1);
    queue_word(32'h7fff_ffff, 1'b1);
    queue_word(32'h0000_0000, 1'b0);
    queue_word(32'h0000_0000, 1'b0);
    queue_word(32'hffff_ffff, 1'b1);
    // words after a match end silently
    queue_word(32'hffff_ffff, 1'b0);
    queue_word(32'h0000_0001, 1'b0);
    queue_word(32'h0000_0002, 1'b1);
    // slot reloaded in the middle of a buffer
    queue_word(32'h0000_0005, 1'b0);
    queue_load(mwps_pkg::SLOT_W'(0), 32'h0000_0005, 32'hffff_ffff);
    queue_word(32'h0000_0005, 1'b1);

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      apb_write(mwps_pkg::ADDR_PATTERN_WORDS, mwps_pkg::APB_DATA_W'(cfg_plan[p]));
      apb_check(mwps_pkg::ADDR_PATTERN_WORDS, cfg_plan[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      phase_items = 0;
      repeat ($urandom_range(3, 1)) queue_random_load();
      while (phase_items < PHASE_ITEMS) begin
        if ($urandom_range(6) == 0) queue_random_load();
        queue_buffer();
      end
      if (p == 4) begin
        @(posedge clk_i);
        hold_arm <= 1'b1;
        @(posedge clk_i);
        hold_arm <= 1'b0;
      end
    end
    wait_idle();

    $display("covered %0d buffer words and %0d slot loads over %0d window settings",
             words_taken, loads_taken, NUM_PHASES + 1);
    $display("results checked: %0d found, %0d not found", found_cnt, miss_cnt);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/mwps_pkg.sv
hdl/mwps_cell.sv
hdl/mwps_outbuf.sv
hdl/masked_word_pattern_search.sv
verif/testbench.sv
